// File: sv/hash_set_insert_probing_assert.svh
// Assertion macros for the hash set insert block.
`ifndef HASH_SET_INSERT_PROBING_ASSERT_SVH
`define HASH_SET_INSERT_PROBING_ASSERT_SVH

`ifndef SYNTHESIS
`define HSIP_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("hsip: same-cycle check failed");
`define HSIP_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("hsip: next-cycle check failed");
`else
`define HSIP_ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`define HSIP_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

// File: sv/hsip_pkg.sv
`default_nettype none

package hsip_pkg;

   localparam int POS_W      = 10;
   localparam int TABLE_SIZE = 1 << POS_W;
   localparam int KEY_W      = 31;
   localparam int SLOT_W     = 10;
   localparam int STATUS_W   = 2;
   localparam int STEP_W     = POS_W + 1;
   localparam int ENTRY_W    = KEY_W + 1;

   typedef enum logic [STATUS_W-1:0] {
      ST_ADDED   = 2'd0,
      ST_PRESENT = 2'd1,
      ST_FULL    = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      S_CLEAR,
      S_IDLE,
      S_PROBE
   } state_type;

   // one access to the table memory per cycle
   typedef struct packed {
      logic               we;
      logic               re;
      logic [POS_W-1:0]   addr;
      logic [ENTRY_W-1:0] wdata;
   } mem_req_type;

endpackage

`default_nettype wire

// File: sv/hsip_if.sv
`default_nettype none

interface hsip_req_if
   import hsip_pkg::*;
();
   logic             valid;
   logic             ready;
   logic [KEY_W-1:0] key;

   modport source (output valid, output key, input ready);
   modport sink   (input valid, input key, output ready);
endinterface

interface hsip_rsp_if
   import hsip_pkg::*;
();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [SLOT_W-1:0]   slot;

   modport source (output valid, output status, output slot, input ready);
   modport sink   (input valid, input status, input slot, output ready);
endinterface

`default_nettype wire

// File: sv/hsip_ram.sv
`default_nettype none

module hsip_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wdata,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      // read data holds until the next read
      if (re) begin
         rdata_ff <= mem_ff[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// File: sv/hsip_ctrl.sv
`default_nettype none

module hsip_ctrl
   import hsip_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   hsip_req_if.sink                 req_chan,
   hsip_rsp_if.source               rsp_chan,
   output mem_req_type              mem_req,
   input  wire logic [ENTRY_W-1:0]  mem_rdata
);

   state_type          state_ff, state_in;
   logic [POS_W-1:0]   clr_ff, clr_in;
   logic [KEY_W-1:0]   key_ff, key_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic               rsp_valid_ff, rsp_valid_in;
   status_type         status_ff, status_in;
   logic [SLOT_W-1:0]  slot_ff, slot_in;

   logic               occ;
   logic               hit;
   logic               last_step;
   logic               out_free;
   logic [STEP_W-1:0]  step_inc;
   logic [POS_W-1:0]   next_pos;

   assign occ       = mem_rdata[KEY_W];
   assign hit       = mem_rdata[KEY_W-1:0] == key_ff;
   assign last_step = step_ff == STEP_W'(TABLE_SIZE);
   assign out_free  = !rsp_valid_ff || rsp_chan.ready;
   assign step_inc  = step_ff + STEP_W'(1);
   // triangular walk: slot + i, wrapped by the power-of-two table size
   assign next_pos  = pos_ff + step_inc[POS_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      key_ff    <= key_in;
      pos_ff    <= pos_in;
      step_ff   <= step_in;
      status_ff <= status_in;
      slot_ff   <= slot_in;
   end

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      key_in       = key_ff;
      pos_in       = pos_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      status_in    = status_ff;
      slot_in      = slot_ff;
      mem_req      = '0;
      req_chan.ready = 1'b0;

      unique case (state_ff)
         S_CLEAR: begin
            mem_req.we    = 1'b1;
            mem_req.addr  = clr_ff;
            mem_req.wdata = '0;
            clr_in        = clr_ff + POS_W'(1);
            if (clr_ff == POS_W'(TABLE_SIZE - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_chan.ready = 1'b1;
            if (req_chan.valid) begin
               key_in       = req_chan.key;
               pos_in       = req_chan.key[POS_W-1:0];
               step_in      = '0;
               mem_req.re   = 1'b1;
               mem_req.addr = req_chan.key[POS_W-1:0];
               state_in     = S_PROBE;
            end
         end
         S_PROBE: begin
            if (!occ || hit || last_step) begin
               // hold the read data until the result register frees up
               if (out_free) begin
                  rsp_valid_in = 1'b1;
                  slot_in      = SLOT_W'(pos_ff);
                  if (!occ) begin
                     status_in     = ST_ADDED;
                     mem_req.we    = 1'b1;
                     mem_req.addr  = pos_ff;
                     mem_req.wdata = {1'b1, key_ff};
                  end else if (hit) begin
                     status_in = ST_PRESENT;
                  end else begin
                     status_in = ST_FULL;
                  end
                  state_in = S_IDLE;
               end
            end else begin
               step_in      = step_inc;
               pos_in       = next_pos;
               mem_req.re   = 1'b1;
               mem_req.addr = next_pos;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   assign rsp_chan.valid  = rsp_valid_ff;
   assign rsp_chan.status = status_ff;
   assign rsp_chan.slot   = slot_ff;

endmodule

`default_nettype wire

// File: sv/hash_set_insert_probing.sv
`default_nettype none
// Channel   Dir  Handshake      Payload
// req_chan  in   valid/ready    key[30:0]
// rsp_chan  out  valid/ready    status[1:0], slot[9:0]
//
// An insert makes n table reads on its probe chain (1 to 1025), one at a time
// through the single table RAM port. After reset a clearing pass writes all
// 1024 entries with req_chan.ready low. A stalled rsp_chan holds the finishing
// insert in its last probe; a new request is still taken while a response waits.

`include "hash_set_insert_probing_assert.svh"

module hash_set_insert_probing
   import hsip_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   hsip_req_if.sink   req_chan,
   hsip_rsp_if.source rsp_chan
);

   mem_req_type        mem_req;
   logic [ENTRY_W-1:0] mem_rdata;

   hsip_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .mem_req   (mem_req),
      .mem_rdata (mem_rdata)
   );

   // entry: {occupied, key}
   hsip_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_SIZE)
   ) u_table (
      .clock (clock),
      .we    (mem_req.we),
      .re    (mem_req.re),
      .addr  (mem_req.addr),
      .wdata (mem_req.wdata),
      .rdata (mem_rdata)
   );

   `HSIP_ASSERT_IMPLY(a_single_port, clock, reset, mem_req.we, !mem_req.re)
   `HSIP_ASSERT_IMPLY(a_home_read, clock, reset, req_chan.valid && req_chan.ready, mem_req.re && mem_req.addr == req_chan.key[POS_W-1:0])
   `HSIP_ASSERT_NEXT(a_insert_reports, clock, reset, mem_req.we && mem_req.wdata[KEY_W], rsp_chan.valid && rsp_chan.status == ST_ADDED)

endmodule

`default_nettype wire
